FILE: src/ring_stop_inject_eject_macros.svh
// assertion helpers for the ring stop; they expect clk and arst_n in scope
`ifndef RING_STOP_INJECT_EJECT_MACROS_SVH
`define RING_STOP_INJECT_EJECT_MACROS_SVH

// condition holds at every clock edge out of reset
`define RSIE_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("ring stop invariant violated");

// antecedent implies consequent in the same cycle
`define RSIE_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ring stop implication violated");

`endif

FILE: src/rsie_pkg.sv
`default_nettype none
package rsie_pkg;

	localparam int LANES_DEF        = 2;
	localparam int INJECT_DEPTH_DEF = 4;
	localparam int EJECT_DEPTH_DEF  = 4;

	localparam int ADDR_W    = 6;
	localparam int PAYLOAD_W = 32;
	localparam int FLIT_W    = ADDR_W + PAYLOAD_W;

	typedef struct packed {
		logic fwd;
		logic inj_pop;
		logic ej_pop;
		logic accepted;
		logic dropped;
		logic arrived;
	} rsie_ctl_t;

endpackage
`default_nettype wire

FILE: src/rsie_ram.sv
`default_nettype none
module rsie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: src/ring_stop_inject_eject.sv
// Timing: an accepted item is registered in stage s1 (with its queue RAM read),
// then in output stage s2 once that stage is free; it is held while out_ready is low.
// Throughput: one item per cycle, out_ready permitting; per-lane head/count
// registers update at accept; queue RAMs take one write, one read per cycle.
// Reset (arst_n low): queue heads, counts, node address and pipeline valids
// clear at once; queue entries stay undefined until written.
`default_nettype none
`include "ring_stop_inject_eject_macros.svh"
module ring_stop_inject_eject
	import rsie_pkg::*;
#(
	parameter int LANES        = LANES_DEF,
	parameter int INJECT_DEPTH = INJECT_DEPTH_DEF,
	parameter int EJECT_DEPTH  = EJECT_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [ADDR_W-1:0]    cfg_wdata,
	input  wire logic                 in_valid,
	output      logic                 in_ready,
	input  wire logic                 lane,
	input  wire logic                 ring_valid,
	input  wire logic [ADDR_W-1:0]    ring_dest,
	input  wire logic [PAYLOAD_W-1:0] ring_payload,
	input  wire logic                 node_valid,
	input  wire logic [ADDR_W-1:0]    node_dest,
	input  wire logic [PAYLOAD_W-1:0] node_payload,
	input  wire logic                 node_ready,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      logic                 ring_out_valid,
	output      logic [ADDR_W-1:0]    ring_out_dest,
	output      logic [PAYLOAD_W-1:0] ring_out_payload,
	output      logic                 node_out_valid,
	output      logic [PAYLOAD_W-1:0] node_out_payload,
	output      logic                 node_accepted,
	output      logic                 eject_dropped,
	output      logic                 arrived
);
	localparam int LW   = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int IIW  = (INJECT_DEPTH > 1) ? $clog2(INJECT_DEPTH) : 1;
	localparam int EIW  = (EJECT_DEPTH > 1) ? $clog2(EJECT_DEPTH) : 1;
	localparam int ICW  = $clog2(INJECT_DEPTH + 1);
	localparam int ECW  = $clog2(EJECT_DEPTH + 1);
	localparam int IRD  = LANES * INJECT_DEPTH;
	localparam int ERD  = LANES * EJECT_DEPTH;
	localparam int IAW  = (IRD > 1) ? $clog2(IRD) : 1;
	localparam int EAW  = (ERD > 1) ? $clog2(ERD) : 1;

	logic [ADDR_W-1:0] node_address_q;

	logic [ICW-1:0] inj_count_q [LANES];
	logic [IIW-1:0] inj_head_q  [LANES];
	logic [ECW-1:0] ej_count_q  [LANES];
	logic [EIW-1:0] ej_head_q   [LANES];

	logic              valid_s1;
	rsie_ctl_t         ctl_s1;
	logic [ADDR_W-1:0]    ring_dest_s1;
	logic [PAYLOAD_W-1:0] ring_pay_s1;

	logic                 valid_s2;
	logic                 ring_out_valid_s2;
	logic [ADDR_W-1:0]    ring_out_dest_s2;
	logic [PAYLOAD_W-1:0] ring_out_payload_s2;
	logic                 node_out_valid_s2;
	logic [PAYLOAD_W-1:0] node_out_payload_s2;
	logic                 node_accepted_s2;
	logic                 eject_dropped_s2;
	logic                 arrived_s2;

	logic              accept;
	logic              advance;
	logic [LW-1:0]     lane_idx;
	logic [ICW-1:0]    ic;
	logic [IIW-1:0]    ih;
	logic [ECW-1:0]    ec;
	logic [EIW-1:0]    eh;
	logic              hit;
	logic              fwd;
	logic              push_ej;
	logic              drop;
	logic              pop_inj;
	logic              push_inj;
	logic              pop_ej;
	logic [ICW:0]      inj_sum;
	logic [ECW:0]      ej_sum;
	logic [IIW-1:0]    inj_tail;
	logic [EIW-1:0]    ej_tail;
	logic [IIW-1:0]    ih_next;
	logic [EIW-1:0]    eh_next;
	logic [ICW-1:0]    ic_next;
	logic [ECW-1:0]    ec_next;
	logic [IAW-1:0]    inj_waddr;
	logic [IAW-1:0]    inj_raddr;
	logic [EAW-1:0]    ej_waddr;
	logic [EAW-1:0]    ej_raddr;
	logic [FLIT_W-1:0]    inj_rdata;
	logic [PAYLOAD_W-1:0] ej_rdata;
	rsie_ctl_t         ctl_s0;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;
	assign lane_idx = LW'(lane);

	always_comb begin
		ic = inj_count_q[lane_idx];
		ih = inj_head_q[lane_idx];
		ec = ej_count_q[lane_idx];
		eh = ej_head_q[lane_idx];

		hit      = ring_valid && (ring_dest == node_address_q);
		fwd      = ring_valid && !hit;
		push_ej  = hit && (ec != ECW'(EJECT_DEPTH));
		drop     = hit && (ec == ECW'(EJECT_DEPTH));
		pop_inj  = !fwd && (ic != '0);
		push_inj = node_valid && (ic != ICW'(INJECT_DEPTH));
		pop_ej   = node_ready && (ec != '0);

		inj_sum  = (ICW+1)'(ih) + (ICW+1)'(ic);
		inj_tail = (inj_sum >= (ICW+1)'(INJECT_DEPTH))
			? IIW'(inj_sum - (ICW+1)'(INJECT_DEPTH)) : IIW'(inj_sum);
		ej_sum   = (ECW+1)'(eh) + (ECW+1)'(ec);
		ej_tail  = (ej_sum >= (ECW+1)'(EJECT_DEPTH))
			? EIW'(ej_sum - (ECW+1)'(EJECT_DEPTH)) : EIW'(ej_sum);

		ih_next = (ih == IIW'(INJECT_DEPTH - 1)) ? '0 : ih + IIW'(1);
		eh_next = (eh == EIW'(EJECT_DEPTH - 1)) ? '0 : eh + EIW'(1);
		ic_next = ic + ICW'(push_inj) - ICW'(pop_inj);
		ec_next = ec + ECW'(push_ej) - ECW'(pop_ej);

		inj_waddr = IAW'(lane_idx) * IAW'(INJECT_DEPTH) + IAW'(inj_tail);
		inj_raddr = IAW'(lane_idx) * IAW'(INJECT_DEPTH) + IAW'(ih);
		ej_waddr  = EAW'(lane_idx) * EAW'(EJECT_DEPTH) + EAW'(ej_tail);
		ej_raddr  = EAW'(lane_idx) * EAW'(EJECT_DEPTH) + EAW'(eh);

		ctl_s0.fwd      = fwd;
		ctl_s0.inj_pop  = pop_inj;
		ctl_s0.ej_pop   = pop_ej;
		ctl_s0.accepted = push_inj;
		ctl_s0.dropped  = drop;
		ctl_s0.arrived  = push_ej;
	end

	rsie_ram #(
		.WIDTH(FLIT_W),
		.DEPTH(IRD)
	) u_inject_ram (
		.clk  (clk),
		.we   (accept && push_inj),
		.waddr(inj_waddr),
		.wdata({node_dest, node_payload}),
		.re   (accept && pop_inj),
		.raddr(inj_raddr),
		.rdata(inj_rdata)
	);

	rsie_ram #(
		.WIDTH(PAYLOAD_W),
		.DEPTH(ERD)
	) u_eject_ram (
		.clk  (clk),
		.we   (accept && push_ej),
		.waddr(ej_waddr),
		.wdata(ring_payload),
		.re   (accept && pop_ej),
		.raddr(ej_raddr),
		.rdata(ej_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_address_q <= '0;
		end else if (cfg_we) begin
			node_address_q <= cfg_wdata;
		end
	end

	// advance the selected lane's queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				inj_count_q[i] <= '0;
				inj_head_q[i]  <= '0;
				ej_count_q[i]  <= '0;
				ej_head_q[i]   <= '0;
			end
		end else if (accept) begin
			inj_count_q[lane_idx] <= ic_next;
			ej_count_q[lane_idx]  <= ec_next;
			if (pop_inj) begin
				inj_head_q[lane_idx] <= ih_next;
			end
			if (pop_ej) begin
				ej_head_q[lane_idx] <= eh_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1       <= ctl_s0;
			ring_dest_s1 <= ring_dest;
			ring_pay_s1  <= ring_payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// merge forwarded flit, injected flit and ejected payload
	always_ff @(posedge clk) begin
		if (advance) begin
			ring_out_valid_s2 <= ctl_s1.fwd || ctl_s1.inj_pop;
			if (ctl_s1.fwd) begin
				ring_out_dest_s2    <= ring_dest_s1;
				ring_out_payload_s2 <= ring_pay_s1;
			end else if (ctl_s1.inj_pop) begin
				ring_out_dest_s2    <= inj_rdata[FLIT_W-1:PAYLOAD_W];
				ring_out_payload_s2 <= inj_rdata[PAYLOAD_W-1:0];
			end else begin
				ring_out_dest_s2    <= '0;
				ring_out_payload_s2 <= '0;
			end
			node_out_valid_s2   <= ctl_s1.ej_pop;
			node_out_payload_s2 <= ctl_s1.ej_pop ? ej_rdata : '0;
			node_accepted_s2    <= ctl_s1.accepted;
			eject_dropped_s2    <= ctl_s1.dropped;
			arrived_s2          <= ctl_s1.arrived;
		end
	end

	assign out_valid        = valid_s2;
	assign ring_out_valid   = ring_out_valid_s2;
	assign ring_out_dest    = ring_out_dest_s2;
	assign ring_out_payload = ring_out_payload_s2;
	assign node_out_valid   = node_out_valid_s2;
	assign node_out_payload = node_out_payload_s2;
	assign node_accepted    = node_accepted_s2;
	assign eject_dropped    = eject_dropped_s2;
	assign arrived          = arrived_s2;

	generate
		for (genvar g = 0; g < LANES; g++) begin : g_lane_chk
			`RSIE_ASSERT_ALWAYS(a_inj_count_bound, inj_count_q[g] <= ICW'(INJECT_DEPTH))
			`RSIE_ASSERT_ALWAYS(a_ej_count_bound, ej_count_q[g] <= ECW'(EJECT_DEPTH))
		end
	endgenerate

	`RSIE_ASSERT_IMPL(a_stall_only_when_full, !in_ready, valid_s1 && out_valid && !out_ready)

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
module testbench;
	import rsie_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		bit                 lane;
		bit                 ring_valid;
		bit [ADDR_W-1:0]    ring_dest;
		bit [PAYLOAD_W-1:0] ring_payload;
		bit                 node_valid;
		bit [ADDR_W-1:0]    node_dest;
		bit [PAYLOAD_W-1:0] node_payload;
		bit                 node_ready;
	} tick_t;

	typedef struct packed {
		bit                 ring_out_valid;
		bit [ADDR_W-1:0]    ring_out_dest;
		bit [PAYLOAD_W-1:0] ring_out_payload;
		bit                 node_out_valid;
		bit [PAYLOAD_W-1:0] node_out_payload;
		bit                 node_accepted;
		bit                 eject_dropped;
		bit                 arrived;
	} stop_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ADDR_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic lane = 1'b0;
	logic ring_valid = 1'b0;
	logic [ADDR_W-1:0] ring_dest = '0;
	logic [PAYLOAD_W-1:0] ring_payload = '0;
	logic node_valid = 1'b0;
	logic [ADDR_W-1:0] node_dest = '0;
	logic [PAYLOAD_W-1:0] node_payload = '0;
	logic node_ready = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic ring_out_valid;
	logic [ADDR_W-1:0] ring_out_dest;
	logic [PAYLOAD_W-1:0] ring_out_payload;
	logic node_out_valid;
	logic [PAYLOAD_W-1:0] node_out_payload;
	logic node_accepted;
	logic eject_dropped;
	logic arrived;

	ring_stop_inject_eject #(
		.LANES(LANES_DEF),
		.INJECT_DEPTH(INJECT_DEPTH_DEF),
		.EJECT_DEPTH(EJECT_DEPTH_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.lane(lane),
		.ring_valid(ring_valid),
		.ring_dest(ring_dest),
		.ring_payload(ring_payload),
		.node_valid(node_valid),
		.node_dest(node_dest),
		.node_payload(node_payload),
		.node_ready(node_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ring_out_valid(ring_out_valid),
		.ring_out_dest(ring_out_dest),
		.ring_out_payload(ring_out_payload),
		.node_out_valid(node_out_valid),
		.node_out_payload(node_out_payload),
		.node_accepted(node_accepted),
		.eject_dropped(eject_dropped),
		.arrived(arrived)
	);

	// predictor state, per lane
	bit [FLIT_W-1:0]    inject_fifo [LANES_DEF][INJECT_DEPTH_DEF];
	int                 inject_fill [LANES_DEF];
	int                 inject_rd [LANES_DEF];
	bit [PAYLOAD_W-1:0] eject_fifo [LANES_DEF][EJECT_DEPTH_DEF];
	int                 eject_fill [LANES_DEF];
	int                 eject_rd [LANES_DEF];
	bit [ADDR_W-1:0]    stop_addr = '0;

	stop_out_t owed_outputs[$];
	stop_out_t want;
	int errors = 0;
	int ticks_sent = 0;
	int outputs_seen = 0;
	int arrivals_seen = 0;
	int drops_seen = 0;
	int injects_seen = 0;
	int addr_writes = 0;
	int stall_left = 0;
	bit steady = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic stop_out_t advance_stop(input tick_t t);
		stop_out_t r;
		int ln;
		int ic;
		int ih;
		int ec;
		int eh;
		bit fwd;
		r = '0;
		ln = t.lane;
		ic = inject_fill[ln];
		ih = inject_rd[ln];
		ec = eject_fill[ln];
		eh = eject_rd[ln];
		fwd = 1'b0;
		if (t.ring_valid) begin
			if (t.ring_dest == stop_addr) begin
				if (ec < EJECT_DEPTH_DEF) begin
					eject_fifo[ln][(eh + ec) % EJECT_DEPTH_DEF] = t.ring_payload;
					eject_fill[ln]++;
					r.arrived = 1'b1;
				end else begin
					r.eject_dropped = 1'b1;
				end
			end else begin
				fwd = 1'b1;
				r.ring_out_valid = 1'b1;
				r.ring_out_dest = t.ring_dest;
				r.ring_out_payload = t.ring_payload;
			end
		end
		if (!fwd && ic > 0) begin
			r.ring_out_valid = 1'b1;
			{r.ring_out_dest, r.ring_out_payload} = inject_fifo[ln][ih];
			inject_rd[ln] = (ih + 1) % INJECT_DEPTH_DEF;
			inject_fill[ln]--;
		end
		if (t.node_valid && ic < INJECT_DEPTH_DEF) begin
			inject_fifo[ln][(ih + ic) % INJECT_DEPTH_DEF] = {t.node_dest, t.node_payload};
			inject_fill[ln]++;
			r.node_accepted = 1'b1;
		end
		if (t.node_ready && ec > 0) begin
			r.node_out_valid = 1'b1;
			r.node_out_payload = eject_fifo[ln][eh];
			eject_rd[ln] = (eh + 1) % EJECT_DEPTH_DEF;
			eject_fill[ln]--;
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic tick_t make_tick(input bit ln, input bit rv, input bit [ADDR_W-1:0] rd,
			input bit [PAYLOAD_W-1:0] rp, input bit nv, input bit [ADDR_W-1:0] nd,
			input bit [PAYLOAD_W-1:0] np, input bit nr);
		tick_t t;
		t.lane = ln;
		t.ring_valid = rv;
		t.ring_dest = rd;
		t.ring_payload = rp;
		t.node_valid = nv;
		t.node_dest = nd;
		t.node_payload = np;
		t.node_ready = nr;
		return t;
	endfunction

	function automatic tick_t rand_tick(input int p_local, input int p_node, input int p_ready);
		bit [ADDR_W-1:0] rd;
		rd = $urandom_range(0, 63);
		if ($urandom_range(0, 99) < p_local)
			rd = stop_addr;
		return make_tick($urandom_range(0, 1), $urandom_range(0, 99) < 80, rd, $urandom,
			$urandom_range(0, 99) < p_node, $urandom_range(0, 63), $urandom,
			$urandom_range(0, 99) < p_ready);
	endfunction

	task automatic offer_tick(input tick_t t);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		lane <= t.lane;
		ring_valid <= t.ring_valid;
		ring_dest <= t.ring_dest;
		ring_payload <= t.ring_payload;
		node_valid <= t.node_valid;
		node_dest <= t.node_dest;
		node_payload <= t.node_payload;
		node_ready <= t.node_ready;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		owed_outputs.push_back(advance_stop(t));
		ticks_sent++;
	endtask

	// call at the edge where the last item was taken
	task automatic stop_sending();
		in_valid <= 1'b0;
	endtask

	task automatic drain_outputs();
		stop_sending();
		wait (owed_outputs.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_stop_addr(input bit [ADDR_W-1:0] a);
		drain_outputs();
		cfg_we <= 1'b1;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
		stop_addr = a;
		addr_writes++;
	endtask

	task automatic run_random(input int n, input int p_local, input int p_node, input int p_ready);
		int i;
		for (i = 0; i < n; i++) begin
			steady = ((i / 50) % 3) == 1;
			offer_tick(rand_tick(p_local, p_node, p_ready));
		end
		steady = 1'b0;
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (owed_outputs.size() == 0) begin
				$error("output with no item outstanding");
				errors++;
			end else begin
				want = owed_outputs.pop_front();
				check_field("ring_out_valid", want.ring_out_valid, ring_out_valid);
				check_field("ring_out_dest", want.ring_out_dest, ring_out_dest);
				check_field("ring_out_payload", want.ring_out_payload, ring_out_payload);
				check_field("node_out_valid", want.node_out_valid, node_out_valid);
				check_field("node_out_payload", want.node_out_payload, node_out_payload);
				check_field("node_accepted", want.node_accepted, node_accepted);
				check_field("eject_dropped", want.eject_dropped, eject_dropped);
				check_field("arrived", want.arrived, arrived);
				outputs_seen++;
				arrivals_seen += want.arrived;
				drops_seen += want.eject_dropped;
				injects_seen += want.node_accepted;
			end
		end
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			if (!steady && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	task automatic test_directed();
		int i;
		// pass-through at the extremes, node flit taken
		offer_tick(make_tick(0, 1, 6'h3f, 32'hffff_ffff, 1, 6'h00, 32'h0, 1));
		// arrival into empty eject queue with node ready: no bypass; inject head leaves
		offer_tick(make_tick(0, 1, 6'h00, 32'h0, 0, 6'h3f, 32'hffff_ffff, 1));
		offer_tick(make_tick(0, 0, 6'h15, 32'h5555_aaaa, 0, 6'h2a, 32'haaaa_5555, 1));
		// fill lane 1 eject queue and overflow
		for (i = 0; i < 5; i++)
			offer_tick(make_tick(1, 1, 6'h00, $urandom, 0, 6'h00, 32'h0, 0));
		// full queue: pop does not make room
		offer_tick(make_tick(1, 1, 6'h00, $urandom, 0, 6'h00, 32'h0, 1));
		for (i = 0; i < 4; i++)
			offer_tick(make_tick(1, 0, 6'h00, 32'h0, 0, 6'h00, 32'h0, 1));
		// ring busy: fill lane 0 inject queue and overflow
		for (i = 0; i < 5; i++)
			offer_tick(make_tick(0, 1, 6'h05, $urandom, 1, $urandom_range(0, 63), $urandom, 0));
		// full inject queue with free slot: pop, no push
		offer_tick(make_tick(0, 0, 6'h00, 32'h0, 1, 6'h3f, $urandom, 0));
		for (i = 0; i < 4; i++)
			offer_tick(make_tick(0, 0, 6'h00, 32'h0, 0, 6'h00, 32'h0, 0));
	endtask

	task automatic test_mixed_traffic();
		set_stop_addr(6'h3f);
		run_random(250, 30, 50, 50);
	endtask

	task automatic test_sender_pause();
		run_random(40, 30, 60, 40);
		drain_outputs();
		run_random(40, 30, 60, 40);
	endtask

	task automatic test_eject_pressure();
		set_stop_addr(6'h2a);
		run_random(300, 60, 30, 25);
	endtask

	task automatic test_inject_pressure();
		set_stop_addr($urandom_range(1, 62));
		run_random(150, 10, 85, 70);
		set_stop_addr(6'h00);
		run_random(150, 15, 80, 60);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_mixed_traffic();
		test_sender_pause();
		test_eject_pressure();
		test_inject_pressure();
		drain_outputs();
		repeat (4) @(posedge clk);
		$display("%0d ticks over %0d address settings, %0d outputs checked", ticks_sent,
			addr_writes + 1, outputs_seen);
		$display("%0d arrivals, %0d eject drops, %0d node flits injected", arrivals_seen,
			drops_seen, injects_seen);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d outputs outstanding", CYCLE_LIMIT,
			owed_outputs.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/rsie_pkg.sv
src/rsie_ram.sv
src/ring_stop_inject_eject.sv
sim/testbench.sv
